@@ sv/pim_pkg.sv @@
// Shared types and status codes for the priority inheritance mutex.
// No dependencies; used by pim_queue, pim_core and the top level.
package pim_pkg;

  localparam int ID_W   = 4;
  localparam int PRIO_W = 8;

  localparam logic [2:0] ST_GRANTED  = 3'd0;
  localparam logic [2:0] ST_BLOCKED  = 3'd1;
  localparam logic [2:0] ST_HANDED   = 3'd2;
  localparam logic [2:0] ST_UNLOCKED = 3'd3;
  localparam logic [2:0] ST_IGNORED  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam logic ACT_LOCK   = 1'b0;
  localparam logic ACT_UNLOCK = 1'b1;

  // Input word, action in the lowest bit
  typedef struct packed {
    logic [PRIO_W-1:0] task_priority;
    logic [ID_W-1:0]   task_id;
    logic              action;
  } pim_req_t;

  // Result word, status in the lowest bits
  typedef struct packed {
    logic              yield_request;
    logic [ID_W-1:0]   wake_id;
    logic              wake_valid;
    logic [PRIO_W-1:0] restored_priority;
    logic              boosted;
    logic [PRIO_W-1:0] owner_priority;
    logic              locked_now;
    logic [ID_W-1:0]   owner_id;
    logic [2:0]        status;
  } pim_res_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } pim_waiter_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    pim_waiter_t entry;
  } pim_qcmd_t;

  typedef struct packed {
    logic        empty;
    logic        full;
    pim_waiter_t head;
  } pim_qstat_t;

endpackage

@@ sv/pim_queue.sv @@
// Ring-buffer FIFO of waiting tasks with a prefetched head entry.
// Depends on pim_pkg.
module pim_queue #(
  parameter int MAX_TASKS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  pim_pkg::pim_qcmd_t cmd,
  output pim_pkg::pim_qstat_t stat
);
  import pim_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  pim_waiter_t        waiters [MAX_TASKS];
  pim_waiter_t        head_q;
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   head_next;
  logic [IDX_W-1:0]   tail;
  logic [IDX_W-1:0]   tail_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    ring_next = (i == IDX_W'(MAX_TASKS - 1)) ? '0 : i + 1'b1;
  endfunction

  always_comb begin
    head_next  = cmd.pop  ? ring_next(head) : head;
    tail_next  = cmd.push ? ring_next(tail) : tail;
    count_next = count;
    if (cmd.push) begin
      count_next = count + 1'b1;
    end else if (cmd.pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      waiters[tail] <= cmd.entry;
    end
  end

  // Prefetch the entry at the next head; forward a word written there this cycle
  always_ff @(posedge clk) begin
    if (cmd.push && (tail == head_next)) begin
      head_q <= cmd.entry;
    end else begin
      head_q <= waiters[head_next];
    end
  end

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(MAX_TASKS));
  assign stat.head  = head_q;

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.full)
    else $error("push into a full waiter queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stat.empty)
    else $error("pop from an empty waiter queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_TASKS))
    else $error("waiter count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    stat.empty |-> (head == tail))
    else $error("empty queue with head and tail apart");

endmodule

@@ sv/pim_core.sv @@
// Ownership and priority inheritance logic: holder registers and the result
// for one request. Depends on pim_pkg; drives pim_queue through pim_qcmd_t.
module pim_core #(
  parameter int PRIORITY_LEVELS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  pim_pkg::pim_req_t   req,
  input  pim_pkg::pim_qstat_t qstat,
  output pim_pkg::pim_qcmd_t  qcmd,
  output pim_pkg::pim_res_t   res
);
  import pim_pkg::*;

  localparam int PRIO_MAX = PRIORITY_LEVELS - 1;

  logic              locked;
  logic              locked_next;
  logic [ID_W-1:0]   holder_id;
  logic [ID_W-1:0]   holder_id_next;
  logic [PRIO_W-1:0] holder_prio;
  logic [PRIO_W-1:0] holder_prio_next;
  logic [PRIO_W-1:0] base_prio;
  logic [PRIO_W-1:0] base_prio_next;
  logic [PRIO_W-1:0] prio;

  always_comb begin
    // Saturate priorities beyond the configured levels
    if (32'(req.task_priority) >= PRIO_MAX) begin
      prio = PRIO_W'(PRIO_MAX);
    end else begin
      prio = req.task_priority;
    end

    locked_next      = locked;
    holder_id_next   = holder_id;
    holder_prio_next = holder_prio;
    base_prio_next   = base_prio;
    qcmd.push        = 1'b0;
    qcmd.pop         = 1'b0;
    qcmd.entry.id    = req.task_id;
    qcmd.entry.prio  = prio;
    res              = '0;

    if (req.action == ACT_LOCK) begin
      if (!locked) begin
        locked_next      = 1'b1;
        holder_id_next   = req.task_id;
        holder_prio_next = prio;
        base_prio_next   = prio;
        res.status       = ST_GRANTED;
      end else if (qstat.full) begin
        res.status = ST_FULL;
      end else begin
        qcmd.push = fire;
        if (prio > holder_prio) begin
          holder_prio_next = prio;
          res.boosted      = 1'b1;
        end
        res.yield_request = 1'b1;
        res.status        = ST_BLOCKED;
      end
    end else begin
      if (!locked || (holder_id != req.task_id)) begin
        res.status = ST_IGNORED;
      end else begin
        res.restored_priority = base_prio;
        if (!qstat.empty) begin
          qcmd.pop          = fire;
          holder_id_next    = qstat.head.id;
          holder_prio_next  = qstat.head.prio;
          base_prio_next    = qstat.head.prio;
          res.wake_valid    = 1'b1;
          res.wake_id       = qstat.head.id;
          res.yield_request = (qstat.head.prio > base_prio);
          res.status        = ST_HANDED;
        end else begin
          locked_next      = 1'b0;
          holder_id_next   = '0;
          holder_prio_next = '0;
          base_prio_next   = '0;
          res.status       = ST_UNLOCKED;
        end
      end
    end

    res.locked_now     = locked_next;
    res.owner_id       = locked_next ? holder_id_next : '0;
    res.owner_priority = locked_next ? holder_prio_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      locked      <= 1'b0;
      holder_id   <= '0;
      holder_prio <= '0;
      base_prio   <= '0;
    end else if (fire) begin
      locked      <= locked_next;
      holder_id   <= holder_id_next;
      holder_prio <= holder_prio_next;
      base_prio   <= base_prio_next;
    end
  end

  a_free_clear: assert property (@(posedge clk) disable iff (rst)
    !locked |-> (holder_id == '0 && holder_prio == '0 && base_prio == '0))
    else $error("free mutex with stale holder state");

  a_boost_ge_base: assert property (@(posedge clk) disable iff (rst)
    locked |-> (holder_prio >= base_prio))
    else $error("effective priority below base priority");

  a_queue_needs_owner: assert property (@(posedge clk) disable iff (rst)
    !locked |-> qstat.empty)
    else $error("waiters queued on a free mutex");

endmodule

@@ sv/priority_inheritance_mutex.sv @@
// Top level of the priority inheritance mutex: input register, result register
// and the stream handshake. Depends on pim_pkg, pim_queue and pim_core.
//
// One lock or unlock word is taken per clock cycle while ready is high, and
// each gives one result word: the word waits in the input register, then the
// decision logic, the holder registers and the waiter ring are updated
// together as the result register loads. The waiter ring's head entry is
// prefetched into a register, so a hand-over waits for no memory read. Ready
// drops only while the result register is full and not being taken.
module priority_inheritance_mutex #(
  parameter int MAX_TASKS       = 16,
  parameter int PRIORITY_LEVELS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] action, [4:1] task_id, [12:5] task_priority, [15:13] zero
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [6:3] owner_id, [7] locked_now, [15:8] owner_priority,
  // [16] boosted, [24:17] restored_priority, [25] wake_valid, [29:26] wake_id,
  // [30] yield_request, [31] zero
  output logic [31:0] m_axis_tdata
);
  import pim_pkg::*;

  logic       in_valid;
  pim_req_t   in_req;
  logic       out_free;
  logic       fire;
  pim_res_t   res;
  pim_res_t   res_q;
  pim_qcmd_t  qcmd;
  pim_qstat_t qstat;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && out_free;
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req <= s_axis_tdata[$bits(pim_req_t)-1:0];
    end
  end

  pim_queue #(
    .MAX_TASKS (MAX_TASKS)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .cmd  (qcmd),
    .stat (qstat)
  );

  pim_core #(
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .req   (in_req),
    .qstat (qstat),
    .qcmd  (qcmd),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tdata = {1'b0, res_q};

endmodule

@@ verif/testbench.sv @@
// Self-checking bench for priority_inheritance_mutex: drives lock and unlock words,
// predicts each result word and compares it field by field. Depends on pim_pkg.
module testbench;
  import pim_pkg::*;

  localparam int MAX_TASKS       = 16;
  localparam int PRIORITY_LEVELS = 256;
  localparam int STALL_LIMIT     = 2000;
  localparam int RANDOM_WORDS    = 680;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  priority_inheritance_mutex #(
    .MAX_TASKS(MAX_TASKS),
    .PRIORITY_LEVELS(PRIORITY_LEVELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pim_req_t pending_reqs[$];
  pim_res_t results_due[$];
  int       send_idle_pct = 28;
  int       recv_idle_pct = 86;
  int       words_issued = 0;
  int       results_seen = 0;
  int       mismatches = 0;
  int       stall_cycles = 0;
  bit       word_in_taken = 1'b0;

  // Predicted mutex state
  logic              mx_locked = 1'b0;
  logic [ID_W-1:0]   mx_holder = '0;
  logic [PRIO_W-1:0] mx_prio = '0;
  logic [PRIO_W-1:0] mx_base_prio = '0;
  logic [ID_W-1:0]   ring_ids[MAX_TASKS];
  logic [PRIO_W-1:0] ring_prios[MAX_TASKS];
  int                ring_head = 0;
  int                ring_tail = 0;
  int                ring_count = 0;

  // Ownership as the stimulus sees it, so unlocks can target the holder
  bit              plan_locked = 1'b0;
  logic [ID_W-1:0] plan_owner = '0;
  logic [ID_W-1:0] plan_waiters[$];

  function automatic int ring_next(int i);
    return (i == MAX_TASKS - 1) ? 0 : i + 1;
  endfunction

  function automatic pim_res_t mutex_step(pim_req_t req);
    pim_res_t          r;
    int                p;
    logic [PRIO_W-1:0] wprio;
    r = '0;
    p = int'(req.task_priority);
    if (p >= PRIORITY_LEVELS - 1) p = PRIORITY_LEVELS - 1;
    if (req.action == ACT_LOCK) begin
      if (!mx_locked) begin
        mx_locked    = 1'b1;
        mx_holder    = req.task_id;
        mx_prio      = p[PRIO_W-1:0];
        mx_base_prio = p[PRIO_W-1:0];
        r.status     = ST_GRANTED;
      end else if (ring_count >= MAX_TASKS) begin
        r.status = ST_FULL;
      end else begin
        ring_ids[ring_tail]   = req.task_id;
        ring_prios[ring_tail] = p[PRIO_W-1:0];
        ring_tail  = ring_next(ring_tail);
        ring_count++;
        if (p > int'(mx_prio)) begin
          mx_prio   = p[PRIO_W-1:0];
          r.boosted = 1'b1;
        end
        r.yield_request = 1'b1;
        r.status        = ST_BLOCKED;
      end
    end else if (!mx_locked || mx_holder != req.task_id) begin
      r.status = ST_IGNORED;
    end else begin
      r.restored_priority = mx_base_prio;
      if (ring_count > 0) begin
        wprio        = ring_prios[ring_head];
        mx_holder    = ring_ids[ring_head];
        ring_head    = ring_next(ring_head);
        ring_count--;
        mx_prio      = wprio;
        mx_base_prio = wprio;
        r.wake_valid    = 1'b1;
        r.wake_id       = mx_holder;
        r.yield_request = wprio > r.restored_priority;
        r.status        = ST_HANDED;
      end else begin
        mx_locked    = 1'b0;
        mx_holder    = '0;
        mx_prio      = '0;
        mx_base_prio = '0;
        r.status     = ST_UNLOCKED;
      end
    end
    if (mx_locked) begin
      r.owner_id       = mx_holder;
      r.owner_priority = mx_prio;
    end
    r.locked_now = mx_locked;
    return r;
  endfunction

  // Queue a request word and track who will hold the mutex
  function automatic void queue_request(logic act, logic [ID_W-1:0] tid,
                                        logic [PRIO_W-1:0] prio);
    pim_req_t req;
    req.action        = act;
    req.task_id       = tid;
    req.task_priority = prio;
    pending_reqs.push_back(req);
    words_issued++;
    if (act == ACT_LOCK) begin
      if (!plan_locked) begin
        plan_locked = 1'b1;
        plan_owner  = tid;
      end else if (plan_waiters.size() < MAX_TASKS) begin
        plan_waiters.push_back(tid);
      end
    end else if (plan_locked && plan_owner == tid) begin
      if (plan_waiters.size() != 0) begin
        plan_owner = plan_waiters.pop_front();
      end else begin
        plan_locked = 1'b0;
      end
    end
  endfunction

  // Alternate lock-heavy and unlock-heavy stretches so the ring fills and drains
  task automatic run_random(int n);
    int                made;
    int                lock_bias;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   tid;
    made      = 0;
    lock_bias = 50;
    while (made < n) begin
      if (made % 40 == 0) lock_bias = $urandom_range(15, 90);
      made++;
      if ($urandom_range(0, 99) < 5) begin
        queue_request(ACT_UNLOCK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 99) < lock_bias) begin
        case ($urandom_range(0, 7))
          0:       prio = '0;
          1:       prio = '1;
          default: prio = 8'($urandom_range(0, 255));
        endcase
        queue_request(ACT_LOCK, 4'($urandom_range(0, 15)), prio);
      end else begin
        tid = (plan_locked && $urandom_range(0, 99) < 85) ? plan_owner
                                                           : 4'($urandom_range(0, 15));
        queue_request(ACT_UNLOCK, tid, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  function automatic bit field_bad(string fname, int got, int want);
    if (got == want) return 1'b0;
    if (mismatches < 10)
      $display("mismatch on %s at result %0d: expected %0d, got %0d",
               fname, results_seen, want, got);
    return 1'b1;
  endfunction

  task automatic check_result(pim_res_t got, pim_res_t want);
    bit bad;
    bad = field_bad("status", int'(got.status), int'(want.status));
    bad |= field_bad("owner_id", int'(got.owner_id), int'(want.owner_id));
    bad |= field_bad("locked_now", int'(got.locked_now), int'(want.locked_now));
    bad |= field_bad("owner_priority", int'(got.owner_priority),
                     int'(want.owner_priority));
    bad |= field_bad("boosted", int'(got.boosted), int'(want.boosted));
    bad |= field_bad("restored_priority", int'(got.restored_priority),
                     int'(want.restored_priority));
    bad |= field_bad("wake_valid", int'(got.wake_valid), int'(want.wake_valid));
    bad |= field_bad("wake_id", int'(got.wake_id), int'(want.wake_id));
    bad |= field_bad("yield_request", int'(got.yield_request), int'(want.yield_request));
    if (bad) mismatches++;
  endtask

  // Drive on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || word_in_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tdata  <= {3'b000, pending_reqs.pop_front()};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  // Sample on the rising edge: predict each accepted word, check each result word
  always @(posedge clk) begin
    word_in_taken = 1'b0;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        results_due.push_back(mutex_step(pim_req_t'(s_axis_tdata[12:0])));
        word_in_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          if (mismatches < 10) $display("unexpected result word %h", m_axis_tdata);
          mismatches++;
        end else begin
          check_result(pim_res_t'(m_axis_tdata[30:0]), results_due.pop_front());
        end
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: free unlock, grant, stranger unlock, owner relock, boost, fill to full
    queue_request(ACT_UNLOCK, 4'd0, 8'd0);
    queue_request(ACT_LOCK, 4'd0, 8'd0);
    queue_request(ACT_UNLOCK, 4'd5, 8'd255);
    queue_request(ACT_LOCK, 4'd0, 8'd0);
    queue_request(ACT_LOCK, 4'd15, 8'd255);
    for (int i = 1; i <= 13; i++)
      queue_request(ACT_LOCK, 4'(i), 8'($urandom_range(0, 254)));
    queue_request(ACT_LOCK, 4'd14, 8'd128);
    queue_request(ACT_LOCK, 4'd7, 8'd200);
    queue_request(ACT_UNLOCK, 4'd0, 8'd0);
    queue_request(ACT_UNLOCK, 4'd0, 8'd17);
    queue_request(ACT_UNLOCK, 4'd15, 8'd255);
    // hold further words until every result is back
    wait (results_seen == words_issued);

    run_random(RANDOM_WORDS / 3);
    wait (results_seen == words_issued);
    send_idle_pct = 86;
    recv_idle_pct = 28;
    run_random(RANDOM_WORDS / 3);
    wait (results_seen == words_issued);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));
    wait (results_seen == words_issued);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/pim_pkg.sv
sv/pim_queue.sv
sv/pim_core.sv
sv/priority_inheritance_mutex.sv
verif/testbench.sv
